@@ hdl/cdc_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// cdc_pkg
// Shared types, codes and calendar helpers for the date counter.
// ----------------------------------------------------------------------------
package cdc_pkg;

  typedef enum logic [1:0] {
    REQ_SET  = 2'd0,
    REQ_PRE  = 2'd1,
    REQ_POST = 2'd2,
    REQ_ADD  = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_EMIT
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic accept;
    logic step;
    logic emit;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_add;
    logic cnt_zero;
    logic out_free;
  } stat_t;

  localparam logic [3:0]  MONTH_FIRST = 4'd1;
  localparam logic [3:0]  MONTH_LAST  = 4'd12;
  localparam logic [4:0]  DAY_FIRST   = 5'd1;
  localparam logic [11:0] YEAR_MIN    = 12'd1900;
  localparam logic [11:0] YEAR_MAX    = 12'd2100;
  localparam logic [11:0] YEAR_TOP    = 12'd4095;
  // base for the year-mod-400 residue of a loaded year (1600 is a multiple of 400)
  localparam logic [11:0] YEAR_BASE   = 12'd1600;
  localparam logic [8:0]  CYCLE_LEN   = 9'd400;
  localparam logic [8:0]  CYCLE_LAST  = 9'd399;
  localparam logic [8:0]  CENT_1      = 9'd100;
  localparam logic [8:0]  CENT_2      = 9'd200;
  localparam logic [8:0]  CENT_3      = 9'd300;
  // residue of the reset year 1900
  localparam logic [8:0]  RESET_RES   = 9'd300;

  function automatic logic is_leap(input logic [8:0] res400, input logic [1:0] year_lo);
    is_leap = (res400 == 9'd0) ||
              ((res400 != CENT_1) && (res400 != CENT_2) && (res400 != CENT_3) &&
               (year_lo == 2'd0));
  endfunction

  function automatic logic [4:0] days_in(input logic [3:0] month, input logic leap);
    case (month)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: days_in = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    days_in = 5'd30;
      4'd2:                                       days_in = leap ? 5'd29 : 5'd28;
      default:                                    days_in = 5'd0;
    endcase
  endfunction

endpackage
`default_nettype wire

@@ hdl/cdc_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// cdc_if
// Valid/ready channels for requests and returned dates.
// ----------------------------------------------------------------------------
interface cdc_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [3:0]  set_month;
  logic [4:0]  set_day;
  logic [11:0] set_year;
  logic [15:0] day_count;

  modport source (output valid, req_type, set_month, set_day, set_year, day_count,
                  input ready);
  modport sink   (input valid, req_type, set_month, set_day, set_year, day_count,
                  output ready);
endinterface

interface cdc_rsp_if;
  logic        valid;
  logic        ready;
  logic [3:0]  out_month;
  logic [4:0]  out_day;
  logic [11:0] out_year;
  logic        limit_hit;

  modport source (output valid, out_month, out_day, out_year, limit_hit, input ready);
  modport sink   (input valid, out_month, out_day, out_year, limit_hit, output ready);
endinterface
`default_nettype wire

@@ hdl/cdc_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// cdc_ctrl
// Request sequencer: takes a request, runs the day loop, hands off the result.
// ----------------------------------------------------------------------------
module cdc_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire cdc_pkg::stat_t stat,
  output cdc_pkg::cmd_t      cmd
);

  cdc_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cdc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      cdc_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_next = stat.is_add ? cdc_pkg::ST_RUN : cdc_pkg::ST_EMIT;
        end
      end
      cdc_pkg::ST_RUN: begin
        if (stat.cnt_zero) begin
          state_next = cdc_pkg::ST_EMIT;
        end
      end
      cdc_pkg::ST_EMIT: begin
        if (stat.out_free) begin
          state_next = cdc_pkg::ST_IDLE;
        end
      end
      default: state_next = cdc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready   = 1'b0;
    cmd.accept = 1'b0;
    cmd.step   = 1'b0;
    cmd.emit   = 1'b0;
    case (state)
      cdc_pkg::ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      cdc_pkg::ST_RUN:  cmd.step = !stat.cnt_zero;
      cdc_pkg::ST_EMIT: cmd.emit = stat.out_free;
      default: ;
    endcase
  end

endmodule
`default_nettype wire

@@ hdl/cdc_datapath.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// cdc_datapath
// Date registers, one-day advance logic, day counter and output register.
// ----------------------------------------------------------------------------
module cdc_datapath #(
  parameter int CNT_W = 16
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire cdc_pkg::cmd_t cmd,
  output cdc_pkg::stat_t     stat,
  input  wire logic [1:0]    req_type,
  input  wire logic [3:0]    set_month,
  input  wire logic [4:0]    set_day,
  input  wire logic [11:0]   set_year,
  input  wire logic [15:0]   day_count,
  output logic               out_valid,
  input  wire logic          out_ready,
  output logic [3:0]         out_month,
  output logic [4:0]         out_day,
  output logic [11:0]        out_year,
  output logic               limit_hit
);

  logic [3:0]       cur_month;
  logic [4:0]       cur_day;
  logic [11:0]      cur_year;
  logic [8:0]       cur_res;      // cur_year mod 400
  logic [CNT_W-1:0] days_left;
  logic             hit;
  logic             use_snap;
  logic [3:0]       snap_month;
  logic [4:0]       snap_day;
  logic [11:0]      snap_year;

  // one-day advance
  logic       leap;
  logic [4:0] dim;
  logic [3:0] adv_month;
  logic [4:0] adv_day;
  logic [11:0] adv_year;
  logic [8:0] adv_res;
  logic       adv_refused;

  always_comb begin
    leap        = cdc_pkg::is_leap(cur_res, cur_year[1:0]);
    dim         = cdc_pkg::days_in(cur_month, leap);
    adv_month   = cur_month;
    adv_day     = cur_day;
    adv_year    = cur_year;
    adv_res     = cur_res;
    adv_refused = 1'b0;
    if (cur_day != dim) begin
      adv_day = cur_day + 5'd1;
    end else if (cur_month < cdc_pkg::MONTH_LAST) begin
      adv_month = cur_month + 4'd1;
      adv_day   = cdc_pkg::DAY_FIRST;
    end else if (cur_year >= cdc_pkg::YEAR_TOP) begin
      adv_refused = 1'b1;
    end else begin
      adv_year  = cur_year + 12'd1;
      adv_month = cdc_pkg::MONTH_FIRST;
      adv_day   = cdc_pkg::DAY_FIRST;
      adv_res   = (cur_res == cdc_pkg::CYCLE_LAST) ? 9'd0 : cur_res + 9'd1;
    end
  end

  // checked load date
  logic [3:0]  ld_month;
  logic [11:0] ld_year;
  logic [11:0] ld_off;
  logic [8:0]  ld_res;
  logic [4:0]  ld_day;

  always_comb begin
    ld_month = (set_month >= cdc_pkg::MONTH_FIRST && set_month <= cdc_pkg::MONTH_LAST)
               ? set_month : cdc_pkg::MONTH_FIRST;
    ld_year  = (set_year >= cdc_pkg::YEAR_MIN && set_year <= cdc_pkg::YEAR_MAX)
               ? set_year : cdc_pkg::YEAR_MIN;
    ld_off   = ld_year - cdc_pkg::YEAR_BASE;
    // offset lies in 300..500: one conditional subtract gives the residue
    ld_res   = (ld_off[8:0] >= cdc_pkg::CYCLE_LEN) ? ld_off[8:0] - cdc_pkg::CYCLE_LEN
                                                   : ld_off[8:0];
    ld_day   = (set_day >= cdc_pkg::DAY_FIRST &&
                set_day <= cdc_pkg::days_in(ld_month,
                                            cdc_pkg::is_leap(ld_res, ld_year[1:0])))
               ? set_day : cdc_pkg::DAY_FIRST;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_month <= cdc_pkg::MONTH_FIRST;
      cur_day   <= cdc_pkg::DAY_FIRST;
      cur_year  <= cdc_pkg::YEAR_MIN;
      cur_res   <= cdc_pkg::RESET_RES;
      days_left <= '0;
      hit       <= 1'b0;
      use_snap  <= 1'b0;
    end else if (cmd.accept) begin
      use_snap <= (req_type != cdc_pkg::REQ_ADD);
      case (req_type)
        cdc_pkg::REQ_SET: begin
          cur_month <= ld_month;
          cur_day   <= ld_day;
          cur_year  <= ld_year;
          cur_res   <= ld_res;
          hit       <= 1'b0;
        end
        cdc_pkg::REQ_PRE, cdc_pkg::REQ_POST: begin
          cur_month <= adv_month;
          cur_day   <= adv_day;
          cur_year  <= adv_year;
          cur_res   <= adv_res;
          hit       <= adv_refused;
        end
        cdc_pkg::REQ_ADD: begin
          days_left <= day_count[CNT_W-1:0];
          hit       <= 1'b0;
        end
        default: ;
      endcase
    end else if (cmd.step) begin
      cur_month <= adv_month;
      cur_day   <= adv_day;
      cur_year  <= adv_year;
      cur_res   <= adv_res;
      hit       <= hit | adv_refused;
      days_left <= days_left - CNT_W'(1);
    end
  end

  // hold the date to return for set and single-step requests
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      case (req_type)
        cdc_pkg::REQ_SET: begin
          snap_month <= ld_month;
          snap_day   <= ld_day;
          snap_year  <= ld_year;
        end
        cdc_pkg::REQ_PRE: begin
          snap_month <= adv_month;
          snap_day   <= adv_day;
          snap_year  <= adv_year;
        end
        default: begin
          snap_month <= cur_month;
          snap_day   <= cur_day;
          snap_year  <= cur_year;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_month <= use_snap ? snap_month : cur_month;
      out_day   <= use_snap ? snap_day   : cur_day;
      out_year  <= use_snap ? snap_year  : cur_year;
      limit_hit <= hit;
    end
  end

  always_comb begin
    stat.is_add   = (req_type == cdc_pkg::REQ_ADD);
    stat.cnt_zero = (days_left == '0);
    stat.out_free = !out_valid || out_ready;
  end

endmodule
`default_nettype wire

@@ hdl/calendar_date_counter_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// calendar_date_counter_core
// Gregorian date counter with set, pre/post-increment and add-days requests.
// ----------------------------------------------------------------------------
// Holds one date (reset 1900-01-01) and returns one date per request. Set,
// pre-increment and post-increment go through the emit state to the output
// register, waiting while an older result is held; add-days first has the
// shared one-day advance unit step the date once per cycle under the day
// counter. The next request is taken in the cycle after the result is
// handed to the output register, even while that result still waits for
// the sink. Only the low COUNT_BITS bits of day_count (at most 16) are used.
// Advancing from 4095-12-31 leaves the date unchanged and sets limit_hit.
module calendar_date_counter_core #(
  parameter int COUNT_BITS = 16
) (
  input  wire logic  clk,
  input  wire logic  rst,
  cdc_req_if.sink    req,
  cdc_rsp_if.source  rsp
);

  localparam int CNT_W = (COUNT_BITS > 16) ? 16 : COUNT_BITS;

  cdc_pkg::cmd_t  cmd;
  cdc_pkg::stat_t stat;

  cdc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  cdc_datapath #(
    .CNT_W (CNT_W)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .req_type  (req.req_type),
    .set_month (req.set_month),
    .set_day   (req.set_day),
    .set_year  (req.set_year),
    .day_count (req.day_count),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .out_month (rsp.out_month),
    .out_day   (rsp.out_day),
    .out_year  (rsp.out_year),
    .limit_hit (rsp.limit_hit)
  );

endmodule
`default_nettype wire

@@ hdl/cdc_checker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// cdc_checker
// Port-level checks on the returned dates of the date counter.
// ----------------------------------------------------------------------------
module cdc_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [3:0]  out_month,
  input wire logic [4:0]  out_day,
  input wire logic [11:0] out_year,
  input wire logic        limit_hit
);

  // a waiting result holds until it is taken
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_month) && $stable(out_day) &&
                               $stable(out_year) && $stable(limit_hit))
    else $error("result changed or dropped while stalled");

  a_date_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_month >= 4'd1 && out_month <= 4'd12 &&
                  out_day >= 5'd1 && out_day <= 5'd31)
    else $error("returned date out of range");

  // the limit can only be met at the last day of the last year
  a_limit_date: assert property (@(posedge clk) disable iff (rst)
    out_valid && limit_hit |-> out_month == 4'd12 && out_day == 5'd31 &&
                               out_year == 12'd4095)
    else $error("limit flag on a date short of the top");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result present straight after reset");

endmodule

bind calendar_date_counter_core cdc_checker u_cdc_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (rsp.valid),
  .out_ready (rsp.ready),
  .out_month (rsp.out_month),
  .out_day   (rsp.out_day),
  .out_year  (rsp.out_year),
  .limit_hit (rsp.limit_hit)
);
`default_nettype wire
